[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every edge outside reset.
`define ORBBD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("orbbd check failed");

// Next-cycle implication.
`define ORBBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("orbbd check failed");

`endif

[src/orbbd_pkg.sv]
`default_nettype none

package orbbd_pkg;

	// Field widths fixed by the port list.
	localparam int REC_W = 64;
	localparam int CNT_W = 7;

	// Operation codes.
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

endpackage

`default_nettype wire

[src/orbbd_ram.sv]
`default_nettype none

module orbbd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[src/overwrite_ring_buffer_burst_drain.sv]
`default_nettype none

// Overwriting ring of DEPTH records with burst drain. A push (op 0) leaves
// busy low, so pushes may follow each other on every cycle; once the ring
// is full each push replaces the oldest record. A drain (op 1) returns
// min(fill, max_count, MAX_BURST) records, oldest first, one per cycle from
// the single read port of the record memory: busy is high while the reads
// are issued, and each result appears in the cycle after its read, shown
// for exactly one cycle under valid, the final one with last set. A drain
// that finds nothing gives a single result in the cycle after the request
// with has_record low and last high, and does not raise busy. There is no
// back-pressure on the result side, so the receiver must take every valid cycle.
module overwrite_ring_buffer_burst_drain #(
	parameter int DEPTH       = 512,
	parameter int RECORD_BITS = 64,
	parameter int MAX_BURST   = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          op,
	input  wire logic [orbbd_pkg::REC_W-1:0]   record_in,
	input  wire logic [orbbd_pkg::CNT_W-1:0]   max_count,
	output logic                               valid,
	output logic [orbbd_pkg::REC_W-1:0]        record_out,
	output logic                               has_record,
	output logic                               last
);

	import orbbd_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int PW = AW + 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = $clog2(MAX_BURST + 1);
	localparam int MW = (FW > CW) ? FW : CW;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                   state_q;
	logic [AW-1:0]          head_q;
	logic [FW-1:0]          fill_q;
	logic [AW-1:0]          rd_q;
	logic [CW-1:0]          remain_q;
	logic                   valid_s1;
	logic                   has_s1;
	logic                   last_s1;

	logic                   accept;
	logic                   push;
	logic                   drain;
	logic [CW-1:0]          req_cap;
	logic [CW-1:0]          n_burst;
	logic [PW-1:0]          diff;
	logic [AW-1:0]          oldest;
	logic [RECORD_BITS-1:0] rdata;

	assign busy   = (state_q == ST_DRAIN);
	assign accept = start && !busy;
	assign push   = accept && (op == OP_PUSH);
	assign drain  = accept && (op == OP_DRAIN);

	always_comb begin
		if (max_count > CNT_W'(MAX_BURST)) begin
			req_cap = CW'(MAX_BURST);
		end else begin
			req_cap = CW'(max_count);
		end
		if (MW'(fill_q) < MW'(req_cap)) begin
			n_burst = CW'(fill_q);
		end else begin
			n_burst = req_cap;
		end
		// Oldest slot is head minus fill, wrapped into the ring.
		diff = PW'(head_q) - PW'(fill_q);
		if (diff[PW-1]) begin
			diff = diff + PW'(DEPTH);
		end
		oldest = diff[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			fill_q   <= '0;
			rd_q     <= '0;
			remain_q <= '0;
			valid_s1 <= 1'b0;
			has_s1   <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			has_s1   <= 1'b0;
			last_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (push) begin
						head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
						if (fill_q != FW'(DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
					end else if (drain) begin
						if (n_burst == '0) begin
							valid_s1 <= 1'b1;
							last_s1  <= 1'b1;
						end else begin
							state_q  <= ST_DRAIN;
							rd_q     <= oldest;
							remain_q <= n_burst;
						end
					end
				end
				ST_DRAIN: begin
					// One read is issued per cycle; its data lands with the strobe.
					valid_s1 <= 1'b1;
					has_s1   <= 1'b1;
					last_s1  <= (remain_q == CW'(1));
					rd_q     <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
					remain_q <= remain_q - 1'b1;
					fill_q   <= fill_q - 1'b1;
					if (remain_q == CW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	orbbd_ram #(
		.WIDTH(RECORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push),
		.waddr(head_q),
		.wdata(record_in[RECORD_BITS-1:0]),
		.raddr(rd_q),
		.rdata(rdata)
	);

	assign valid      = valid_s1;
	assign has_record = has_s1;
	assign last       = last_s1;
	assign record_out = has_s1 ? REC_W'(rdata) : '0;

	`ORBBD_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FW'(DEPTH))
	`ORBBD_ASSERT_NOW(a_drain_count, state_q == ST_DRAIN, remain_q != '0)
	`ORBBD_ASSERT_NEXT(a_burst_end, (state_q == ST_DRAIN) && (remain_q == CW'(1)),
		(state_q == ST_IDLE) && valid && has_record && last)
	`ORBBD_ASSERT_NEXT(a_empty_drain, drain && (n_burst == '0),
		valid && !has_record && last && !busy)

endmodule

`default_nettype wire
